// File: design/isort_pkg.sv
package isort_pkg;

  localparam int DataW        = 32;
  localparam int PosW         = 5;
  localparam int MaxOut       = 32;
  localparam int DepthDefault = 32;

  // output tdata: sorted_value, position, zero fill up to whole bytes
  localparam int OutTdataW = ((DataW + PosW + 7) / 8) * 8;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_EMIT_RD,
    S_EMIT_WAIT
  } state_e;

endpackage

// File: design/insertion_sort_engine.sv
// insertion sort engine for blocks of signed 32-bit values
//
// input stream: one value per request on s_axis, tlast marks the final value of a block.
// each value is inserted into a single-port-read, single-port-write store of DEPTH
// entries. the insertion walks down from the fill point one entry per cycle, and
// s_axis_tready rises again once the value is written in place. values arriving
// with the store full are dropped and the block is flagged (tuser on the output).
// after the request marked tlast the block is read out in order on m_axis, one
// result at a time (memory read, then output register load), up to 32
// results; tlast marks the final one. positions count from 0.
// m_axis has an output register: a stalled receiver holds the current result and
// the read-out simply waits; a new block can start while the final result waits.
// cfg channel: 1-bit direction (0 ascending, 1 descending), always ready. write only
// while the engine is idle; not enforced. equal values keep their arrival order.
// reset clears the fill count, drop flag, direction and all handshake state;
// the store contents need no clearing since only filled entries are read.
module insertion_sort_engine #(
  parameter int DEPTH = isort_pkg::DepthDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic                             cfg_data_i,    // direction
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [isort_pkg::DataW-1:0]      s_axis_tdata,  // value
  input  logic                             s_axis_tlast,  // last
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [isort_pkg::OutTdataW-1:0]  m_axis_tdata,  // sorted_value, position, zeros
  output logic                             m_axis_tlast,  // final_res
  output logic                             m_axis_tuser   // overflow
);
  import isort_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);

  logic signed [DataW-1:0] mem [DEPTH];
  logic signed [DataW-1:0] rdata_q;

  state_e state_q, state_d;
  logic [FW-1:0] fill_q, fill_d;
  logic          dropped_q, dropped_d;
  logic          dir_q;
  logic [AW-1:0] j_q, j_d;
  logic signed [DataW-1:0] key_q, key_d;
  logic          last_q, last_d;
  logic [PosW-1:0] k_q, k_d;

  logic                    m_valid_q, m_valid_d;
  logic signed [DataW-1:0] m_value_q, m_value_d;
  logic [PosW-1:0]         m_pos_q, m_pos_d;
  logic                    m_last_q, m_last_d;
  logic                    m_user_q, m_user_d;

  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic signed [DataW-1:0] wr_data;
  logic          s_accept, full, moves, out_free;
  logic [PosW-1:0] n_m1;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign full          = (fill_q == FW'(DEPTH));
  assign out_free      = !m_valid_q || m_axis_tready;
  assign moves         = (j_q != '0) &&
                         (dir_q ? (key_q > rdata_q) : (key_q < rdata_q));
  // index of the final emitted element, at most 31
  assign n_m1 = (int'(fill_q) >= MaxOut) ? PosW'(MaxOut - 1) : PosW'(int'(fill_q) - 1);

  // store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      fill_q    <= '0;
      dropped_q <= 1'b0;
      dir_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      dropped_q <= dropped_d;
      m_valid_q <= m_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        dir_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    j_q       <= j_d;
    key_q     <= key_d;
    last_q    <= last_d;
    k_q       <= k_d;
    m_value_q <= m_value_d;
    m_pos_q   <= m_pos_d;
    m_last_q  <= m_last_d;
    m_user_q  <= m_user_d;
  end

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    dropped_d = dropped_q;
    j_d       = j_q;
    key_d     = key_q;
    last_d    = last_q;
    k_d       = k_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_value_d = m_value_q;
    m_pos_d   = m_pos_q;
    m_last_d  = m_last_q;
    m_user_d  = m_user_q;
    wr_en     = 1'b0;
    wr_addr   = j_q;
    wr_data   = key_q;
    rd_en     = 1'b1;
    rd_addr   = j_q - AW'(1);

    unique case (state_q)
      S_IDLE: begin
        rd_addr = AW'(fill_q) - AW'(1);
        if (s_accept) begin
          if (full) begin
            dropped_d = 1'b1;
            if (s_axis_tlast) begin
              k_d     = '0;
              state_d = S_EMIT_RD;
            end
          end else begin
            key_d   = s_axis_tdata;
            last_d  = s_axis_tlast;
            j_d     = AW'(fill_q);
            state_d = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        // rdata_q holds entry j-1; when the key moves on, the read for j-2 goes out in parallel
        wr_en = 1'b1;
        if (moves) begin
          wr_data = rdata_q;
          j_d     = j_q - AW'(1);
          rd_addr = j_q - AW'(2);
        end else begin
          wr_data = key_q;
          fill_d  = fill_q + FW'(1);
          k_d     = '0;
          state_d = last_q ? S_EMIT_RD : S_IDLE;
        end
      end
      S_EMIT_RD: begin
        rd_addr = AW'(k_q);
        state_d = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        rd_en = 1'b0;
        if (out_free) begin
          m_valid_d = 1'b1;
          m_value_d = rdata_q;
          m_pos_d   = k_q;
          m_last_d  = (k_q == n_m1);
          m_user_d  = dropped_q;
          if (k_q == n_m1) begin
            fill_d    = '0;
            dropped_d = 1'b0;
            state_d   = S_IDLE;
          end else begin
            k_d     = k_q + PosW'(1);
            state_d = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OutTdataW - DataW - PosW){1'b0}}, m_pos_q, m_value_q};
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tuser  = m_user_q;

endmodule

// File: design/isort_checker.sv
module isort_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             s_axis_tlast,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [isort_pkg::OutTdataW-1:0]  m_axis_tdata,
  input logic                             m_axis_tlast,
  input logic                             m_axis_tuser
);

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // a block read-out is not interleaved with new input
  a_emit_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input accepted in the middle of a read-out");

  // the end of a block always starts work before the next request
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("engine ready right after end of block");

endmodule

bind insertion_sort_engine isort_checker u_isort_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
